FILE: sv/lpfp_pkg.sv
`timescale 1ns / 1ps
// Package for the length-prefixed frame parser: transfer payload types,
// result kind and error codes, configuration register indexes.
// No dependencies.
package lpfp_pkg;

    // Frame body prefix: magic, version, type, header length, payload length
    localparam int unsigned PREFIX_BYTES = 16;

    // Configuration register indexes
    localparam logic [1:0] CFG_MAX_FRAME = 2'd0;
    localparam logic [1:0] CFG_MAGIC     = 2'd1;
    localparam logic [1:0] CFG_VERSION   = 2'd2;

    // Reset values of the configuration registers
    localparam logic [30:0] MAX_FRAME_RESET = 31'd1048576;
    localparam logic [31:0] MAGIC_RESET     = 32'd0;
    localparam logic [15:0] VERSION_RESET   = 16'd1;

    // Result kinds
    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;
    localparam logic [1:0] KIND_EMPTY   = 2'd3;

    // Error codes
    localparam logic [1:0] ERR_FRAME_LEN = 2'd0;
    localparam logic [1:0] ERR_MAGIC_VER = 2'd1;
    localparam logic [1:0] ERR_LEN_SUM   = 2'd2;

    // Input transfer
    typedef struct packed {
        logic [7:0] data_byte;
        logic       chunk_last;
    } lpfp_in_t;

    // Result transfer
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  out_byte;
        logic [15:0] msg_type;
        logic [1:0]  error_code;
        logic        frame_last;
    } lpfp_out_t;

endpackage

FILE: sv/length_prefixed_frame_parser.sv
`timescale 1ns / 1ps
// Length-prefixed frame parser: byte-wide state machine with a result
// register and a one-entry skid stage. Depends on lpfp_pkg.
//
//   channel   | signals                             | direction
//   ----------+-------------------------------------+----------
//   byte      | byte_valid, byte_stall, byte_data   | in
//   item      | item_valid, item_stall, item_data   | out
//   cfg       | cfg_write, cfg_index, cfg_wdata     | in
//
// One byte per cycle while byte_stall is low; each byte goes through the
// state logic in the cycle it is transferred and its result (if any) is
// registered (see the skid stage below). The state update is the only loop.
// Reset returns to reading the length field and loads the register defaults.
// A stalled result parks in the skid stage; byte_stall rises only while the
// skid stage is full, so throughput is one byte per cycle without stalls.
module length_prefixed_frame_parser
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               byte_valid,
    output logic               byte_stall,
    input  lpfp_pkg::lpfp_in_t byte_data,
    output logic               item_valid,
    input  logic               item_stall,
    output lpfp_pkg::lpfp_out_t item_data,
    input  logic               cfg_write,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_wdata
);

    typedef enum logic [2:0] {
        PH_LEN,
        PH_PREFIX,
        PH_BODY,
        PH_SKIP_VER,
        PH_SKIP_LEN,
        PH_DROP
    } phase_t;

    // Configuration
    logic [30:0] max_frame_reg;
    logic [31:0] magic_word_reg;
    logic [15:0] version_word_reg;

    // Parser state
    phase_t      phase_reg,        phase_next;
    logic [30:0] byte_count_reg,   byte_count_next;
    logic [31:0] frame_length_reg, frame_length_next;
    logic [31:0] seen_magic_reg,   seen_magic_next;
    logic [15:0] seen_version_reg, seen_version_next;
    logic [15:0] seen_type_reg,    seen_type_next;
    logic [31:0] header_len_reg,   header_len_next;
    logic [31:0] payload_len_reg,  payload_len_next;

    // Result register and skid stage
    logic                out_valid_reg;
    lpfp_pkg::lpfp_out_t out_data_reg;
    logic                skid_valid_reg;
    lpfp_pkg::lpfp_out_t skid_data_reg;

    logic                accept;
    logic                res_valid;
    lpfp_pkg::lpfp_out_t res;

    assign byte_stall = skid_valid_reg;
    assign accept     = byte_valid & ~byte_stall;
    assign item_valid = out_valid_reg;
    assign item_data  = out_data_reg;

    // Per-byte state update and result
    always_comb
    begin
        logic [7:0]  b;
        logic [30:0] count_inc;
        logic        last;
        logic [31:0] m_val;
        logic [15:0] v_val;
        logic [15:0] t_val;
        logic [31:0] h_val;
        logic [31:0] p_val;
        logic        bad_mv;
        logic        bad_sum;
        logic [31:0] len_shift;

        b         = byte_data.data_byte;
        count_inc = byte_count_reg + 31'd1;
        last      = ({1'b0, count_inc} == frame_length_reg);
        m_val     = seen_magic_reg;
        v_val     = seen_version_reg;
        t_val     = seen_type_reg;
        h_val     = header_len_reg;
        p_val     = payload_len_reg;
        bad_mv    = 1'b0;
        bad_sum   = 1'b0;
        len_shift = {frame_length_reg[23:0], b};

        phase_next        = phase_reg;
        byte_count_next   = byte_count_reg;
        frame_length_next = frame_length_reg;
        seen_magic_next   = seen_magic_reg;
        seen_version_next = seen_version_reg;
        seen_type_next    = seen_type_reg;
        header_len_next   = header_len_reg;
        payload_len_next  = payload_len_reg;

        res_valid      = 1'b0;
        res.kind       = lpfp_pkg::KIND_ERROR;
        res.out_byte   = 8'd0;
        res.msg_type   = seen_type_reg;
        res.error_code = 2'd0;
        res.frame_last = 1'b1;

        case (phase_reg)
            PH_PREFIX:
            begin
                // shift the byte into the field it belongs to
                if (byte_count_reg < 31'd4)
                    m_val = {seen_magic_reg[23:0], b};
                else if (byte_count_reg < 31'd6)
                    v_val = {seen_version_reg[7:0], b};
                else if (byte_count_reg < 31'd8)
                    t_val = {seen_type_reg[7:0], b};
                else if (byte_count_reg < 31'd12)
                    h_val = {header_len_reg[23:0], b};
                else
                    p_val = {payload_len_reg[23:0], b};

                // fields cut short by the body length count as zero
                if (frame_length_reg < 32'd4)  m_val = '0;
                if (frame_length_reg < 32'd6)  v_val = '0;
                if (frame_length_reg < 32'd8)  t_val = '0;
                if (frame_length_reg < 32'd12) h_val = '0;
                if (frame_length_reg < 32'd16) p_val = '0;

                bad_mv  = (m_val != magic_word_reg) || (v_val != version_word_reg);
                bad_sum = (34'(lpfp_pkg::PREFIX_BYTES) + {2'b00, h_val} + {2'b00, p_val})
                          != {2'b00, frame_length_reg};

                seen_magic_next   = m_val;
                seen_version_next = v_val;
                seen_type_next    = t_val;
                header_len_next   = h_val;
                payload_len_next  = p_val;
                byte_count_next   = count_inc;

                if (last)
                begin
                    res_valid    = 1'b1;
                    res.msg_type = t_val;
                    if (bad_mv)
                        res.error_code = lpfp_pkg::ERR_MAGIC_VER;
                    else if (bad_sum)
                        res.error_code = lpfp_pkg::ERR_LEN_SUM;
                    else
                        res.kind = lpfp_pkg::KIND_EMPTY;
                    phase_next        = PH_LEN;
                    byte_count_next   = '0;
                    frame_length_next = '0;
                end
                else if (count_inc >= 31'(lpfp_pkg::PREFIX_BYTES))
                begin
                    if (bad_mv)
                        phase_next = PH_SKIP_VER;
                    else if (bad_sum)
                        phase_next = PH_SKIP_LEN;
                    else
                        phase_next = PH_BODY;
                end
            end

            PH_BODY:
            begin
                res_valid      = 1'b1;
                res.out_byte   = b;
                res.frame_last = last;
                if ({2'b00, byte_count_reg} <
                    (33'(lpfp_pkg::PREFIX_BYTES) + {1'b0, header_len_reg}))
                    res.kind = lpfp_pkg::KIND_HEADER;
                else
                    res.kind = lpfp_pkg::KIND_PAYLOAD;
                byte_count_next = count_inc;
                if (last)
                begin
                    phase_next        = PH_LEN;
                    byte_count_next   = '0;
                    frame_length_next = '0;
                end
            end

            PH_SKIP_VER, PH_SKIP_LEN:
            begin
                byte_count_next = count_inc;
                if (last)
                begin
                    res_valid      = 1'b1;
                    res.error_code = (phase_reg == PH_SKIP_VER) ?
                                     lpfp_pkg::ERR_MAGIC_VER : lpfp_pkg::ERR_LEN_SUM;
                    phase_next        = PH_LEN;
                    byte_count_next   = '0;
                    frame_length_next = '0;
                end
            end

            PH_DROP:
            begin
                if (byte_data.chunk_last)
                begin
                    phase_next        = PH_LEN;
                    byte_count_next   = '0;
                    frame_length_next = '0;
                end
            end

            default:
            begin
                // reading the big-endian body length
                phase_next        = PH_LEN;
                frame_length_next = len_shift;
                byte_count_next   = count_inc;
                if (count_inc >= 31'd4)
                begin
                    byte_count_next = '0;
                    if ((len_shift == 32'd0) || (len_shift > {1'b0, max_frame_reg}))
                    begin
                        res_valid      = 1'b1;
                        res.msg_type   = 16'd0;
                        res.error_code = lpfp_pkg::ERR_FRAME_LEN;
                        if (byte_data.chunk_last)
                        begin
                            phase_next        = PH_LEN;
                            frame_length_next = '0;
                        end
                        else
                            phase_next = PH_DROP;
                    end
                    else
                    begin
                        phase_next        = PH_PREFIX;
                        seen_magic_next   = '0;
                        seen_version_next = '0;
                        seen_type_next    = '0;
                        header_len_next   = '0;
                        payload_len_next  = '0;
                    end
                end
            end
        endcase
    end

    // State, configuration, result register and skid stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_frame_reg    <= lpfp_pkg::MAX_FRAME_RESET;
            magic_word_reg   <= lpfp_pkg::MAGIC_RESET;
            version_word_reg <= lpfp_pkg::VERSION_RESET;
            phase_reg        <= PH_LEN;
            byte_count_reg   <= '0;
            frame_length_reg <= '0;
            seen_magic_reg   <= '0;
            seen_version_reg <= '0;
            seen_type_reg    <= '0;
            header_len_reg   <= '0;
            payload_len_reg  <= '0;
            out_valid_reg    <= 1'b0;
            out_data_reg     <= '0;
            skid_valid_reg   <= 1'b0;
            skid_data_reg    <= '0;
        end
        else
        begin
            // configuration writes
            if (cfg_write)
            begin
                case (cfg_index)
                    lpfp_pkg::CFG_MAX_FRAME: max_frame_reg    <= cfg_wdata[30:0];
                    lpfp_pkg::CFG_MAGIC:     magic_word_reg   <= cfg_wdata;
                    lpfp_pkg::CFG_VERSION:   version_word_reg <= cfg_wdata[15:0];
                    default:                 ;
                endcase
            end

            if (accept)
            begin
                phase_reg        <= phase_next;
                byte_count_reg   <= byte_count_next;
                frame_length_reg <= frame_length_next;
                seen_magic_reg   <= seen_magic_next;
                seen_version_reg <= seen_version_next;
                seen_type_reg    <= seen_type_next;
                header_len_reg   <= header_len_next;
                payload_len_reg  <= payload_len_next;
            end

            // result register refills from skid first, else from new result
            if (!out_valid_reg || !item_stall)
            begin
                if (skid_valid_reg)
                begin
                    out_valid_reg  <= 1'b1;
                    out_data_reg   <= skid_data_reg;
                    skid_valid_reg <= 1'b0;
                end
                else
                begin
                    out_valid_reg <= accept & res_valid;
                    out_data_reg  <= res;
                end
            end
            else if (accept && res_valid)
            begin
                skid_valid_reg <= 1'b1;
                skid_data_reg  <= res;
            end
        end
    end

endmodule

FILE: sv/lpfp_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the length-prefixed frame parser, and the bind
// that attaches them. Depends on lpfp_pkg and length_prefixed_frame_parser.
module lpfp_checker
(
    input logic                clk,
    input logic                rst_n,
    input logic                byte_valid,
    input logic                byte_stall,
    input lpfp_pkg::lpfp_in_t  byte_data,
    input logic                item_valid,
    input logic                item_stall,
    input lpfp_pkg::lpfp_out_t item_data
);

    // a stalled byte holds until transferred
    a_byte_hold: assert property (@(posedge clk) disable iff (!rst_n)
        byte_valid && byte_stall |=> byte_valid && $stable(byte_data))
        else $error("byte changed while stalled");

    // a stalled result holds until transferred
    a_item_hold: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_stall |=> item_valid && $stable(item_data))
        else $error("result changed while stalled");

    // input side stalls only behind a stalled result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(byte_stall) |-> $past(item_valid && item_stall))
        else $error("byte_stall rose without a stalled result");

    // skid stage is never full while the result register is empty
    a_stall_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !item_valid |-> !byte_stall)
        else $error("byte_stall with no result pending");

    // errors and empty-frame ends close the frame and carry no byte
    a_end_items: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && (item_data.kind == lpfp_pkg::KIND_ERROR ||
                       item_data.kind == lpfp_pkg::KIND_EMPTY)
        |-> item_data.frame_last && (item_data.out_byte == 8'd0))
        else $error("end item without frame_last or with data");

endmodule

bind length_prefixed_frame_parser lpfp_checker u_lpfp_checker (.*);
